>>> hdl/ctl_pkg.sv
`timescale 1ns / 1ps
// shared types and fixed widths of the closed tour length core
package ctl_pkg;

  // width of the running tour sum, unsigned q36.0
  localparam int SUM_W = 36;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // control that travels with each edge down the pipeline
  typedef struct packed {
    logic valid;
    logic emit;   // closing edge of a tour, result leaves after it
  } tag_t;

endpackage

>>> hdl/ctl_edge_front.sv
`timescale 1ns / 1ps
// tour state, edge issue, absolute differences and squared distance
module ctl_edge_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  input  logic                          last_point_i,
  output logic [2*COORD_WIDTH:0]        sq_sum_o,
  output ctl_pkg::tag_t                 tag_o
);

  localparam int DW = COORD_WIDTH;
  localparam int SS_W = 2 * COORD_WIDTH + 1;

  logic signed [DW-1:0] start_x_q, start_y_q, prior_x_q, prior_y_q;
  logic                 open_q, pend_q;
  logic                 accept;

  logic signed [DW-1:0] op_ax, op_ay;
  logic [DW:0]          diff_x, diff_y, neg_x, neg_y;
  logic [DW-1:0]        mag_x, mag_y;
  logic                 issue;
  ctl_pkg::tag_t        issue_tag;

  logic [DW-1:0]        mag_x_q, mag_y_q;
  logic [2*DW-1:0]      sq_x_q, sq_y_q;
  logic [SS_W-1:0]      sq_sum_q;
  ctl_pkg::tag_t        tag_a_q, tag_b_q, tag_c_q;

  // the closing edge takes a slot of its own after the last point, while pend_q is set
  assign in_stall_o = pend_q || !en_i;
  assign accept     = in_valid_i && !in_stall_o;

  // closing edge runs from the stored start to the stored prior point
  assign op_ax = pend_q ? start_x_q : x_coord_i;
  assign op_ay = pend_q ? start_y_q : y_coord_i;

  assign diff_x = {op_ax[DW-1], op_ax} - {prior_x_q[DW-1], prior_x_q};
  assign diff_y = {op_ay[DW-1], op_ay} - {prior_y_q[DW-1], prior_y_q};
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  assign mag_x  = diff_x[DW] ? neg_x[DW-1:0] : diff_x[DW-1:0];
  assign mag_y  = diff_y[DW] ? neg_y[DW-1:0] : diff_y[DW-1:0];

  // the first point of a tour adds nothing
  assign issue           = pend_q || (accept && open_q);
  assign issue_tag.valid = issue;
  assign issue_tag.emit  = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      prior_x_q <= '0;
      prior_y_q <= '0;
      open_q    <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      if (accept) begin
        if (!open_q) begin
          start_x_q <= x_coord_i;
          start_y_q <= y_coord_i;
        end
        prior_x_q <= x_coord_i;
        prior_y_q <= y_coord_i;
        open_q    <= !last_point_i;
        pend_q    <= last_point_i;
      end else if (en_i && pend_q) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else if (en_i) begin
      tag_a_q <= issue_tag;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_x_q  <= mag_x;
      mag_y_q  <= mag_y;
      sq_x_q   <= mag_x_q * mag_x_q;
      sq_y_q   <= mag_y_q * mag_y_q;
      sq_sum_q <= {1'b0, sq_x_q} + {1'b0, sq_y_q};
    end
  end

  assign sq_sum_o = sq_sum_q;
  assign tag_o    = tag_c_q;

endmodule

>>> hdl/ctl_sqrt_cell.sv
`timescale 1ns / 1ps
// one root bit of the integer square root row
module ctl_sqrt_cell #(
  parameter int REM_W  = 49,
  parameter int ROOT_W = 25,
  parameter int BIT    = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  ctl_pkg::tag_t     tag_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output ctl_pkg::tag_t     tag_o
);

  logic [REM_W:0]    rem_ext, trial, rem_sub;
  logic              take;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  ctl_pkg::tag_t     tag_q;

  // (root + 2^bit)^2 - root^2 = root * 2^(bit+1) + 2^(2*bit)
  assign rem_ext = (REM_W + 1)'(rem_i);
  assign trial   = ((REM_W + 1)'(root_i) << (BIT + 1)) + ((REM_W + 1)'(1) << (2 * BIT));
  assign rem_sub = rem_ext - trial;
  assign take    = rem_ext >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= take ? rem_sub[REM_W-1:0] : rem_i;
      root_q <= take ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign tag_o  = tag_q;

endmodule

>>> hdl/closed_tour_length_core.sv
`timescale 1ns / 1ps
// closed euclidean tour length: edge front end, square root cell row, saturating sum
// pipeline: three front stages, the first in the issue slot of the closing edge,
// COORD_WIDTH + 1 root cells, one sum and output register
// throughput: one point per cycle while the row advances; the last point of a tour
// holds the input while its closing edge is issued
// reset: asynchronous, clears the tour state, the running sum and all pipeline valid bits
module closed_tour_length_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]  x_coord_i,
  input  logic signed [COORD_WIDTH-1:0]  y_coord_i,
  input  logic                           last_point_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ctl_pkg::SUM_W-1:0]      tour_length_o
);

  localparam int ROOT_W = COORD_WIDTH + 1;
  localparam int REM_W  = 2 * COORD_WIDTH + 1;
  localparam int SUM_W  = ctl_pkg::SUM_W;

  logic [REM_W-1:0]  rem_w  [0:ROOT_W];
  logic [ROOT_W-1:0] root_w [0:ROOT_W];
  ctl_pkg::tag_t     tag_w  [0:ROOT_W];

  logic              advance;
  logic              emit_now;
  logic [SUM_W:0]    acc;
  logic [SUM_W-1:0]  sat;
  logic [SUM_W-1:0]  sum_q, out_q;
  logic              out_valid_q;

  // the row only halts when a finished tour cannot enter a full output register
  assign emit_now = tag_w[ROOT_W].valid && tag_w[ROOT_W].emit;
  assign advance  = !(out_valid_q && out_stall_i && emit_now);

  ctl_edge_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .last_point_i (last_point_i),
    .sq_sum_o     (rem_w[0]),
    .tag_o        (tag_w[0])
  );

  assign root_w[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    ctl_sqrt_cell #(
      .REM_W  (REM_W),
      .ROOT_W (ROOT_W),
      .BIT    (ROOT_W - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .rem_i  (rem_w[k]),
      .root_i (root_w[k]),
      .tag_i  (tag_w[k]),
      .rem_o  (rem_w[k+1]),
      .root_o (root_w[k+1]),
      .tag_o  (tag_w[k+1])
    );
  end

  assign acc = {1'b0, sum_q} + (SUM_W + 1)'(root_w[ROOT_W]);
  assign sat = acc[SUM_W] ? ctl_pkg::SUM_MAX : acc[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance && emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && tag_w[ROOT_W].valid) begin
        sum_q <= tag_w[ROOT_W].emit ? '0 : sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit_now) begin
      out_q <= sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tour_length_o = out_q;

  // the input is held in the cycle after a last point is accepted, for its closing edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_point_i) |=> in_stall_o)
    else $error("input not held for the closing edge");

  // a fresh result only comes from the closing edge of a tour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit_now && advance))
    else $error("result raised without a closing edge");

  // the running sum restarts after every emitted tour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit_now) |=> (sum_q == '0))
    else $error("running sum not cleared after a result");

endmodule

>>> sim/closed_tour_length_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the closed tour length core: directed and random tours
module closed_tour_length_core_tb;

  localparam int COORD_W   = 24;
  localparam int LATENCY   = COORD_W + 5;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG  = 5000;

  localparam logic [COORD_W-1:0] C_MIN  = 24'h800000;
  localparam logic [COORD_W-1:0] C_MAX  = 24'h7fffff;
  localparam logic [COORD_W-1:0] C_ZERO = 24'h000000;
  localparam logic [COORD_W-1:0] C_NEG1 = 24'hffffff;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [COORD_W-1:0]  x_coord_i;
  logic signed [COORD_W-1:0]  y_coord_i;
  logic                       last_point_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [ctl_pkg::SUM_W-1:0]  tour_length_o;

  // predicted tour state
  logic signed [COORD_W-1:0]  first_x, first_y, prev_x, prev_y;
  logic [ctl_pkg::SUM_W-1:0]  run_len;
  logic                       in_tour;
  logic [ctl_pkg::SUM_W-1:0]  tour_len_q[$];
  logic [ctl_pkg::SUM_W-1:0]  want_len;

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  bit  hold_long = 1'b0;

  closed_tour_length_core #(
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tour_length_o(tour_length_o)
  );

  always #2 clk_i = ~clk_i;

  // floor of the euclidean distance between two points, exact
  function automatic logic [ctl_pkg::SUM_W-1:0] edge_length(
    logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
    logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]        ux, uy;
    logic [63:0]             sq, root, trial;
    dx = ax - bx;
    dy = ay - by;
    ux = (dx < 0) ? $unsigned(-dx) : $unsigned(dx);
    uy = (dy < 0) ? $unsigned(-dy) : $unsigned(dy);
    sq = 64'(ux) * 64'(ux) + 64'(uy) * 64'(uy);
    root = '0;
    for (int b = COORD_W + 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root[ctl_pkg::SUM_W-1:0];
  endfunction

  function automatic logic [ctl_pkg::SUM_W-1:0] sat_add(
    logic [ctl_pkg::SUM_W-1:0] s, logic [ctl_pkg::SUM_W-1:0] e);
    logic [ctl_pkg::SUM_W:0] t;
    t = {1'b0, s} + {1'b0, e};
    return t[ctl_pkg::SUM_W] ? ctl_pkg::SUM_MAX : t[ctl_pkg::SUM_W-1:0];
  endfunction

  task automatic track_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic last);
    if (!in_tour) begin
      first_x = x;
      first_y = y;
      run_len = '0;
      in_tour = 1'b1;
    end else begin
      run_len = sat_add(run_len, edge_length(x, y, prev_x, prev_y));
    end
    prev_x = x;
    prev_y = y;
    if (last) begin
      run_len = sat_add(run_len, edge_length(first_x, first_y, x, y));
      tour_len_q = {tour_len_q, run_len};
      in_tour = 1'b0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    x_coord_i    <= x;
    y_coord_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    track_point(x, y, last);
    @(negedge clk_i);
  endtask

  // sender pauses until every tour length has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tour_len_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] near);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return r[COORD_W-1:0];
      4, 5, 6:    return near + COORD_W'($urandom_range(0, 512)) - COORD_W'(256);
      7: begin
        case (r[1:0])
          2'd0:    return C_MIN;
          2'd1:    return C_MAX;
          2'd2:    return C_ZERO;
          default: return C_NEG1;
        endcase
      end
      default:    return COORD_W'($urandom_range(0, 2047)) - COORD_W'(1024);
    endcase
  endfunction

  task automatic test_edge_cases();
    // single-point tours give zero
    send_point(C_ZERO, C_ZERO, 1'b1);
    send_point(C_MAX, C_MAX, 1'b1);
    send_point(C_MIN, C_MIN, 1'b1);
    send_point(C_MIN, C_MAX, 1'b1);
    // corner to corner, both ways
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, 1'b1);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b1);
    // full span on one axis
    send_point(C_MIN, C_ZERO, 1'b0);
    send_point(C_MAX, C_ZERO, 1'b1);
    send_point(C_ZERO, C_MIN, 1'b0);
    send_point(C_ZERO, C_MAX, 1'b1);
    // 3-4-5 triangle
    send_point(C_ZERO, C_ZERO, 1'b0);
    send_point(24'h000300, C_ZERO, 1'b0);
    send_point(24'h000300, 24'h000400, 1'b1);
    // repeated point
    send_point(24'h123456, 24'hfedcba, 1'b0);
    send_point(24'h123456, 24'hfedcba, 1'b1);
    // square around the origin
    send_point(24'hffff00, 24'hffff00, 1'b0);
    send_point(24'h000100, 24'hffff00, 1'b0);
    send_point(24'h000100, 24'h000100, 1'b0);
    send_point(24'hffff00, 24'h000100, 1'b1);
    // sub-lsb diagonal, each edge floors to one
    send_point(C_ZERO, C_ZERO, 1'b0);
    send_point(24'h000001, 24'h000001, 1'b1);
  endtask

  // long tour bouncing between corners for a large sum, then a fresh tour
  task automatic test_long_tour();
    for (int i = 0; i < 200; i++) begin
      if (i % 2 == 0) send_point(C_MIN, C_MIN, 1'b0);
      else            send_point(C_MAX, C_MAX, i == 199);
    end
    send_point(C_ZERO, C_ZERO, 1'b0);
    send_point(24'h000400, C_ZERO, 1'b1);
  endtask

  // receiver holds off while short tours keep coming, so the core backs up
  task automatic test_backpressure();
    logic [COORD_W-1:0] px, py;
    px = '0;
    py = '0;
    tx_idle = 1'b0;
    hold_long = 1'b1;
    for (int i = 0; i < 80; i++) begin
      px = pick_coord(px);
      py = pick_coord(py);
      send_point(px, py, i % 2 == 1);
    end
    while (hold_long) @(negedge clk_i);
    tx_idle = 1'b1;
  endtask

  task automatic test_random_tours(int n_items);
    int sent;
    int len;
    int r;
    logic [COORD_W-1:0] px, py;
    sent = 0;
    px = '0;
    py = '0;
    while (sent < n_items) begin
      if (sent > n_items * 4 / 5) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 30);
      else             len = $urandom_range(31, 120);
      for (int i = 0; i < len; i++) begin
        px = pick_coord(px);
        py = pick_coord(py);
        send_point(px, py, i == len - 1);
      end
      sent += len;
    end
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_long = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tour_len_q.size() == 0) begin
        $display("%0t unexpected tour_length: expected none actual %0d", $time, tour_length_o);
        mismatches++;
      end else begin
        want_len = tour_len_q.pop_front();
        if (tour_length_o !== want_len) begin
          $display("%0t tour_length mismatch: expected %0d actual %0d",
                   $time, want_len, tour_length_o);
          mismatches++;
        end
      end
    end
  end

  // no transaction on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t watchdog expired, %0d tour lengths outstanding", $time, tour_len_q.size());
        $display("closed_tour_length_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    x_coord_i    = '0;
    y_coord_i    = '0;
    last_point_i = 1'b0;
    out_stall_i  = 1'b0;
    first_x      = '0;
    first_y      = '0;
    prev_x       = '0;
    prev_y       = '0;
    run_len      = '0;
    in_tour      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_edge_cases();
    drain_results();
    test_long_tour();
    drain_results();
    test_backpressure();
    drain_results();
    test_random_tours(700);
    drain_results();
    if (mismatches == 0 && tour_len_q.size() == 0) begin
      $display("closed_tour_length_core regression: pass");
    end else begin
      $display("closed_tour_length_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ctl_pkg.sv
hdl/ctl_edge_front.sv
hdl/ctl_sqrt_cell.sv
hdl/closed_tour_length_core.sv
sim/closed_tour_length_core_tb.sv
